// ===== sv/wath_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wath_pkg
// Shared constants, item kinds and the queued operation type of the
// word-at-a-time string hash.
// ----------------------------------------------------------------------------
package wath_pkg;

    localparam logic [63:0] GOLDEN_MUL  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] SEED_OFFSET = 64'hCBF2_9CE4_8422_2325;
    localparam int          WORD_SHIFT  = 29;
    localparam int          FIN_SHIFT   = 32;
    localparam int          WORD_BYTES  = 8;

    // default depth of the queue between front and back
    localparam int          QUEUE_DEPTH = 2;

    // what a word does to the running hash
    localparam logic [1:0]  KIND_NONE = 2'd0;
    localparam logic [1:0]  KIND_FULL = 2'd1;
    localparam logic [1:0]  KIND_TAIL = 2'd2;

    typedef struct packed {
        logic [63:0] word;        // already masked to its valid bytes
        logic [1:0]  kind;
        logic        first;
        logic        last;
        logic [31:0] key_length;
    } t_op;

endpackage

// ===== sv/wath_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wath_front
// Accepts input transactions, masks the word to its valid bytes, classifies
// it and holds it in a small queue for the back end.
// ----------------------------------------------------------------------------
module wath_front #(
    parameter int DEPTH = wath_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [63:0]      i_word,
    input  logic [3:0]       i_byte_count,
    input  logic             i_first,
    input  logic             i_last,
    input  logic [31:0]      i_key_length,
    output logic             o_op_valid,
    output wath_pkg::t_op    o_op,
    input  logic             i_op_pop
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wath_pkg::t_op    r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr, n_wr;
    logic [IDX_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    wath_pkg::t_op    w_op;
    logic [63:0]      w_masked;
    logic             w_push;
    logic             w_pop;

    // keep byte i only when it lies below the byte count
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_masked[8*i +: 8] = (4'(i) < i_byte_count) ? i_word[8*i +: 8] : 8'h00;
        end
    end

    always_comb begin
        w_op.word       = w_masked;
        w_op.first      = i_first;
        w_op.last       = i_last;
        w_op.key_length = i_key_length;
        if (i_byte_count == 4'd0) begin
            w_op.kind = wath_pkg::KIND_NONE;
        end else if (i_byte_count >= 4'(wath_pkg::WORD_BYTES)) begin
            w_op.kind = wath_pkg::KIND_FULL;
        end else begin
            w_op.kind = wath_pkg::KIND_TAIL;
        end
    end

    assign o_ready    = (r_cnt != CNT_W'(DEPTH));
    assign o_op_valid = (r_cnt != '0);
    assign o_op       = r_mem[r_rd];
    assign w_push     = i_valid & o_ready;
    assign w_pop      = i_op_pop & o_op_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == IDX_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == IDX_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_op;
        end
    end

endmodule

// ===== sv/wath_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wath_mul
// Low 64 bits of an operand times the golden multiplier, built from one
// shared 32x32 multiplier over four passes.
// ----------------------------------------------------------------------------
module wath_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_prod
);

    localparam logic [1:0] STEP_LL = 2'd0;   // a.lo * g.lo
    localparam logic [1:0] STEP_HL = 2'd1;   // a.hi * g.lo, low half only
    localparam logic [1:0] STEP_LH = 2'd2;   // a.lo * g.hi, low half only
    localparam logic [1:0] STEP_END = 2'd3;

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_step;
    logic [63:0] r_a;
    logic [63:0] r_prod;
    logic [63:0] r_acc;

    logic [31:0] w_x;
    logic [31:0] w_y;
    logic [63:0] w_prod;

    assign w_x    = (r_step == STEP_HL) ? r_a[63:32] : r_a[31:0];
    assign w_y    = (r_step == STEP_LH) ? wath_pkg::GOLDEN_MUL[63:32]
                                        : wath_pkg::GOLDEN_MUL[31:0];
    assign w_prod = w_x * w_y;

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= STEP_LL;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_LL;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_END) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // each pass after the first folds in the product registered by the pass before
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
        end else if (r_busy) begin
            r_prod <= w_prod;
            unique case (r_step)
                STEP_LL:  r_acc <= r_acc;
                STEP_HL:  r_acc <= r_prod;
                STEP_LH:  r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
                STEP_END: r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
            endcase
        end
    end

endmodule

// ===== sv/wath_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wath_back
// Takes queued operations, seeds, absorbs and finalizes the running hash
// through the shared multiplier, and holds the result in an output register.
// ----------------------------------------------------------------------------
module wath_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_op_valid,
    input  wath_pkg::t_op    i_op,
    output logic             o_op_pop,
    output logic             o_mul_start,
    output logic [63:0]      o_mul_a,
    input  logic             i_mul_done,
    input  logic [63:0]      i_mul_prod,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [63:0]      o_hash_value
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SEED = 3'd1;
    localparam logic [2:0] S_ABS  = 3'd2;
    localparam logic [2:0] S_WMUL = 3'd3;
    localparam logic [2:0] S_POST = 3'd4;
    localparam logic [2:0] S_FMUL = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0]    r_state, n_state;
    wath_pkg::t_op r_op, n_op;
    logic [63:0]   r_x, n_x;
    logic [63:0]   r_h, n_h;
    logic [63:0]   r_fin, n_fin;
    logic [63:0]   r_out, n_out;
    logic          r_ov, n_ov;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_x         = r_x;
        n_h         = r_h;
        n_fin       = r_fin;
        n_out       = r_out;
        n_ov        = r_ov & ~i_ready;
        o_op_pop    = 1'b0;
        o_mul_start = 1'b0;
        o_mul_a     = r_x;
        unique case (r_state)
            S_IDLE: begin
                if (i_op_valid) begin
                    o_op_pop = 1'b1;
                    n_op     = i_op;
                    if (i_op.first) begin
                        o_mul_start = 1'b1;
                        o_mul_a     = {32'h0, i_op.key_length};
                        n_state     = S_SEED;
                    end else begin
                        n_x     = r_h;
                        n_state = S_ABS;
                    end
                end
            end
            S_SEED: begin
                if (i_mul_done) begin
                    n_x     = wath_pkg::SEED_OFFSET ^ i_mul_prod;
                    n_state = S_ABS;
                end
            end
            S_ABS: begin
                if (r_op.kind == wath_pkg::KIND_NONE) begin
                    n_state = S_POST;
                end else begin
                    o_mul_start = 1'b1;
                    o_mul_a     = r_x ^ r_op.word;
                    n_state     = S_WMUL;
                end
            end
            S_WMUL: begin
                if (i_mul_done) begin
                    // tail words skip the xor-shift
                    if (r_op.kind == wath_pkg::KIND_FULL) begin
                        n_x = i_mul_prod ^ (i_mul_prod >> wath_pkg::WORD_SHIFT);
                    end else begin
                        n_x = i_mul_prod;
                    end
                    n_state = S_POST;
                end
            end
            S_POST: begin
                n_h = r_x;
                if (r_op.last) begin
                    o_mul_start = 1'b1;
                    o_mul_a     = r_x ^ (r_x >> wath_pkg::FIN_SHIFT);
                    n_state     = S_FMUL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FMUL: begin
                if (i_mul_done) begin
                    n_fin   = i_mul_prod ^ (i_mul_prod >> wath_pkg::WORD_SHIFT);
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ov || i_ready) begin
                    n_out   = r_fin;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_h     <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_h     <= n_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_x   <= n_x;
        r_fin <= n_fin;
        r_out <= n_out;
    end

    assign o_valid      = r_ov;
    assign o_hash_value = r_out;

endmodule

// ===== sv/word_at_a_time_string_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_at_a_time_string_hash
// 64-bit multiplicative hash of a byte key streamed as little-endian words.
// ----------------------------------------------------------------------------
// A key arrives as one or more transactions of up to eight bytes; tuser marks
// the first one (it seeds the hash from key_length) and tlast the final one,
// which yields one 64-bit hash on the master side. Each 64-bit product is
// formed by one shared 32x32 multiplier in four passes; a word with bytes
// needs one product in the back end, a first word one more for the seed and
// a last word one more for the finalizer. A queue of QUEUE_DEPTH entries
// lets the slave side keep accepting while the back end works, and the
// output register lets the next key start while a hash waits to be taken.
// ----------------------------------------------------------------------------
module word_at_a_time_string_hash #(
    parameter int QUEUE_DEPTH = wath_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // word [63:0], byte_count [67:64], key_length [99:68], zero [103:100]
    input  logic [103:0] i_s_axis_tdata,
    // first [0]
    input  logic         i_s_axis_tuser,
    input  logic         i_s_axis_tlast,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // hash_value [63:0]
    output logic [63:0]  o_m_axis_tdata
);

    wath_pkg::t_op w_op;
    logic          w_op_valid;
    logic          w_op_pop;
    logic          w_mul_start;
    logic [63:0]   w_mul_a;
    logic          w_mul_busy;
    logic          w_mul_done;
    logic [63:0]   w_mul_prod;

    wath_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_word       (i_s_axis_tdata[63:0]),
        .i_byte_count (i_s_axis_tdata[67:64]),
        .i_first      (i_s_axis_tuser),
        .i_last       (i_s_axis_tlast),
        .i_key_length (i_s_axis_tdata[99:68]),
        .o_op_valid   (w_op_valid),
        .o_op         (w_op),
        .i_op_pop     (w_op_pop)
    );

    wath_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .o_busy  (w_mul_busy),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    wath_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_valid   (w_op_valid),
        .i_op         (w_op),
        .o_op_pop     (w_op_pop),
        .o_mul_start  (w_mul_start),
        .o_mul_a      (w_mul_a),
        .i_mul_done   (w_mul_done),
        .i_mul_prod   (w_mul_prod),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_hash_value (o_m_axis_tdata)
    );

    // the multiplier is never restarted while a product is in flight
    a_mul_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_start |-> !w_mul_busy)
        else $error("multiplier started while busy");

    // completion is a single-cycle pulse
    a_mul_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |=> !w_mul_done)
        else $error("multiplier done held for more than one cycle");

    // the back end only takes an operation the queue actually holds
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op_pop |-> w_op_valid)
        else $error("queue popped while empty");

endmodule
